// File: rtl/core/sgaf_pkg.sv
// ----------------------------------------------------------------------------
// sgaf_pkg: shared types, constants and tables
// fixed-point formats, saturating add and the exp2/log2 interpolation tables
// ----------------------------------------------------------------------------
package sgaf_pkg;

  localparam int VW = 32;                 // value width, signed Q15.16
  localparam int NCOLS_W = 11;            // columns_in_use register width
  localparam int WGT_W = 17;              // softmax weight width, Q1.16
  localparam int DEF_MAX_COLS = 1024;
  localparam logic [NCOLS_W-1:0] NCOLS_RST = 11'd1024;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] NEG_INF = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_GAP   = 1'b0,
    CFG_NCOLS = 1'b1
  } cfg_idx_e;

  // one queued word between front and back
  typedef struct packed {
    logic signed [VW-1:0] theta;
    logic                 last;
    logic                 first;
    logic                 wrap;
  } item_t;

  function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [VW:0] t;
    t = {a[VW-1], a} + {b[VW-1], b};
    if (t[VW] != t[VW-1]) begin
      sadd = t[VW] ? NEG_INF : VMAX;
    end else begin
      sadd = t[VW-1:0];
    end
  endfunction

  // 2^(-i/16)
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    unique case (i)
      5'd0:  exp2_tab = 17'd65536;
      5'd1:  exp2_tab = 17'd62757;
      5'd2:  exp2_tab = 17'd60097;
      5'd3:  exp2_tab = 17'd57549;
      5'd4:  exp2_tab = 17'd55109;
      5'd5:  exp2_tab = 17'd52773;
      5'd6:  exp2_tab = 17'd50535;
      5'd7:  exp2_tab = 17'd48393;
      5'd8:  exp2_tab = 17'd46341;
      5'd9:  exp2_tab = 17'd44376;
      5'd10: exp2_tab = 17'd42495;
      5'd11: exp2_tab = 17'd40693;
      5'd12: exp2_tab = 17'd38968;
      5'd13: exp2_tab = 17'd37316;
      5'd14: exp2_tab = 17'd35734;
      5'd15: exp2_tab = 17'd34219;
      default: exp2_tab = 17'd32768;
    endcase
  endfunction

  // log2(1 + i/16)
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    unique case (i)
      5'd0:  log2_tab = 17'd0;
      5'd1:  log2_tab = 17'd5732;
      5'd2:  log2_tab = 17'd11136;
      5'd3:  log2_tab = 17'd16248;
      5'd4:  log2_tab = 17'd21098;
      5'd5:  log2_tab = 17'd25711;
      5'd6:  log2_tab = 17'd30109;
      5'd7:  log2_tab = 17'd34312;
      5'd8:  log2_tab = 17'd38336;
      5'd9:  log2_tab = 17'd42196;
      5'd10: log2_tab = 17'd45904;
      5'd11: log2_tab = 17'd49472;
      5'd12: log2_tab = 17'd52911;
      5'd13: log2_tab = 17'd56231;
      5'd14: log2_tab = 17'd59434;
      5'd15: log2_tab = 17'd62534;
      default: log2_tab = 17'd65536;
    endcase
  endfunction

endpackage

// File: rtl/core/sgaf_if.sv
// ----------------------------------------------------------------------------
// sgaf_if: stream and configuration channel interfaces
// valid/ready channels for cells in, results out and register writes
// ----------------------------------------------------------------------------
interface sgaf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sgaf_pkg::VW-1:0]    cell_score;
  logic                              last_cell;
  modport source (output valid, cell_score, last_cell, input ready);
  modport sink (input valid, cell_score, last_cell, output ready);
endinterface

interface sgaf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sgaf_pkg::VW-1:0]    cell_value;
  logic [sgaf_pkg::WGT_W-1:0]        weight_up;
  logic [sgaf_pkg::WGT_W-1:0]        weight_diag;
  logic [sgaf_pkg::WGT_W-1:0]        weight_left;
  logic                              final_score;
  modport source (output valid, cell_value, weight_up, weight_diag, weight_left,
                  final_score, input ready);
  modport sink (input valid, cell_value, weight_up, weight_diag, weight_left,
                final_score, output ready);
endinterface

interface sgaf_cfg_if;
  logic                              valid;
  logic                              ready;
  sgaf_pkg::cfg_idx_e                index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sgaf_ram.sv
// ----------------------------------------------------------------------------
// sgaf_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sgaf_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/sgaf_front.sv
// ----------------------------------------------------------------------------
// sgaf_front: cell intake and position tracking
// tags each word with column, row flags and row end, queues two deep
// ----------------------------------------------------------------------------
module sgaf_front #(
  parameter int MAX_COLS = sgaf_pkg::DEF_MAX_COLS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sgaf_in_if.sink                      in_s,
  input  logic [sgaf_pkg::NCOLS_W-1:0] ncols_i,
  input  logic                         clr_busy_i,
  input  logic                         pop_i,
  output sgaf_pkg::item_t              head_o,
  output logic [$clog2(MAX_COLS)-1:0]  head_col_o,
  output logic                         head_valid_o
);

  localparam int ColW = $clog2(MAX_COLS);
  localparam int CntW = $clog2(MAX_COLS + 1);
  localparam int NcW = (CntW > sgaf_pkg::NCOLS_W) ? CntW : sgaf_pkg::NCOLS_W;

  logic [ColW-1:0]  pos_q, pos_d;
  logic             first_q, first_d;
  sgaf_pkg::item_t  item_q [2];
  logic [ColW-1:0]  col_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  logic [NcW-1:0]   ncols_eff;
  logic [ColW-1:0]  col;
  logic             wrap;
  logic             push;

  always_comb begin
    if (ncols_i == '0) begin
      ncols_eff = NcW'(1);
    end else if (NcW'(ncols_i) > NcW'(MAX_COLS)) begin
      ncols_eff = NcW'(MAX_COLS);
    end else begin
      ncols_eff = NcW'(ncols_i);
    end
    col  = (NcW'(pos_q) >= ncols_eff) ? '0 : pos_q;
    wrap = (NcW'(col) + NcW'(1)) >= ncols_eff;
    if (in_s.last_cell) begin
      pos_d   = '0;
      first_d = 1'b1;
    end else if (wrap) begin
      pos_d   = '0;
      first_d = 1'b0;
    end else begin
      pos_d   = col + ColW'(1);
      first_d = first_q;
    end
  end

  assign in_s.ready   = !clr_busy_i && (cnt_q != 2'd2);
  assign push         = in_s.valid && in_s.ready;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = item_q[rp_q];
  assign head_col_o   = col_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (push) begin
        pos_q   <= pos_d;
        first_q <= first_d;
        wp_q    <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wp_q] <= '{theta: in_s.cell_score, last: in_s.last_cell,
                        first: first_q, wrap: wrap};
      col_q[wp_q]  <= col;
    end
  end

endmodule

// File: rtl/core/sgaf_back.sv
// ----------------------------------------------------------------------------
// sgaf_back: smoothed-max cell sequencer
// candidates, table exp, table log, saturating sum, serial weight divide
// ----------------------------------------------------------------------------
module sgaf_back #(
  parameter int MAX_COLS = sgaf_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [sgaf_pkg::VW-1:0] gap_i,
  input  sgaf_pkg::item_t               head_i,
  input  logic [$clog2(MAX_COLS)-1:0]   head_col_i,
  input  logic                          head_valid_i,
  output logic                          pop_o,
  output logic                          clr_busy_o,
  sgaf_out_if.source                    out_s
);

  localparam int VW = sgaf_pkg::VW;
  localparam int ColW = $clog2(MAX_COLS);
  localparam int ClrW = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_WAIT, S_CAND, S_MAX, S_E1, S_E2, S_E3, S_LN1, S_LN2,
    S_VAL, S_DIVI, S_DIV, S_OUT
  } state_e;

  state_e                state_q;
  logic [ClrW-1:0]       clr_q;
  logic [1:0]            idx_q;
  logic signed [VW-1:0]  cand_q [3];
  logic [2:0]            cv_q;
  logic signed [VW-1:0]  above_q;
  logic signed [VW-1:0]  m_q;
  logic                  mv_q;
  logic [VW-1:0]         d_q [3];
  logic                  ez_q;
  logic [4:0]            k_q;
  logic [15:0]           f_q;
  logic [16:0]           base_q;
  logic [16:0]           e_q [3];
  logic [17:0]           s_q;
  logic [17:0]           l2_q;
  logic [16:0]           ln_q;
  logic signed [VW-1:0]  val_q;
  logic signed [VW-1:0]  left_q, diag_q;
  logic [16:0]           w_q [3];
  logic [17:0]           rem_q;
  logic [16:0]           sh_q;
  logic [4:0]            dcnt_q;

  logic [VW-1:0]         rdata;
  logic                  we;
  logic [ColW-1:0]       waddr;
  logic [VW-1:0]         wdata;

  // combinational helpers
  logic signed [VW-1:0]  old_above, c0, c1, c2, m_c;
  logic                  mv_c;
  logic [VW-1:0]         dsel;
  logic [40:0]           yprod;
  logic [24:0]           y;
  logic [16:0]           t0, t1, tdiff;
  logic [23:0]           iprod;
  logic [20:0]           ebig;
  logic                  ip;
  logic [17:0]           sm;
  logic [15:0]           frac;
  logic [16:0]           l0, l1, lg;
  logic [33:0]           lnprod;
  logic [33:0]           num;
  logic [18:0]           trial;
  logic                  ge;
  logic signed [VW-1:0]  value_c;

  sgaf_ram #(.Width(VW), .Depth(MAX_COLS)) u_row (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_col_i),
    .rdata_o (rdata)
  );

  function automatic logic signed [VW-1:0] add_gap(input logic signed [VW-1:0] v,
                                                   input logic signed [VW-1:0] g);
    add_gap = (v == sgaf_pkg::NEG_INF) ? sgaf_pkg::NEG_INF : sgaf_pkg::sadd(v, g);
  endfunction

  always_comb begin
    // candidates
    old_above = head_i.first ? sgaf_pkg::NEG_INF : rdata;
    c0 = add_gap(old_above, gap_i);
    if (head_col_i == '0) begin
      c1 = head_i.first ? '0 : sgaf_pkg::NEG_INF;
      c2 = sgaf_pkg::NEG_INF;
    end else begin
      c1 = diag_q;
      c2 = add_gap(left_q, gap_i);
    end
    // max over live candidates
    m_c  = sgaf_pkg::NEG_INF;
    mv_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (cv_q[i] && (!mv_c || cand_q[i] > m_c)) begin
        m_c  = cand_q[i];
        mv_c = 1'b1;
      end
    end
    // exp, first step: scale by log2 e
    dsel  = d_q[idx_q];
    yprod = 41'(dsel[23:0]) * 41'd94548;
    y     = yprod[40:16];
    // exp, second step: table interpolation
    t0    = sgaf_pkg::exp2_tab({1'b0, f_q[15:12]});
    t1    = sgaf_pkg::exp2_tab(5'({1'b0, f_q[15:12]}) + 5'd1);
    tdiff = t0 - t1;
    iprod = tdiff[11:0] * f_q[11:0];
    // exp, third step: shift by integer part, round half up
    ebig  = (21'(base_q) + ((21'(1) << k_q) >> 1)) >> k_q;
    // log of the sum
    ip   = (s_q >= 18'd131072);
    sm   = ip ? (s_q >> 1) : s_q;
    if (sm < 18'd65536) begin
      sm = 18'd65536;
    end
    frac = ((sm - 18'd65536) > 18'd65535) ? 16'hFFFF : 16'(sm - 18'd65536);
    l0   = sgaf_pkg::log2_tab({1'b0, frac[15:12]});
    l1   = sgaf_pkg::log2_tab(5'({1'b0, frac[15:12]}) + 5'd1);
    lg   = l0 + 17'(((25'(l1 - l0) * 25'(frac[11:0])) + 25'd2048) >> 12);
    lnprod = 34'(l2_q) * 34'd45426 + 34'd32768;
    // weight divide
    num   = {1'b0, e_q[idx_q], 16'd0} + 34'(s_q >> 1);
    trial = {rem_q, sh_q[16]};
    ge    = (trial >= 19'(s_q));
    value_c = mv_q ? sgaf_pkg::sadd(sgaf_pkg::sadd(m_q, VW'({1'b0, ln_q})), head_i.theta)
                   : sgaf_pkg::NEG_INF;
  end

  assign clr_busy_o = (state_q == S_CLEAR);
  assign we    = (state_q == S_CLEAR) || (state_q == S_VAL);
  assign waddr = (state_q == S_CLEAR) ? clr_q[ColW-1:0] : head_col_i;
  assign wdata = (state_q == S_CLEAR) ? sgaf_pkg::NEG_INF : value_c;
  assign pop_o = (state_q == S_OUT) && (!out_s.valid || out_s.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      left_q    <= sgaf_pkg::NEG_INF;
      diag_q    <= '0;
      out_s.valid <= 1'b0;
    end else begin
      if (pop_o) begin
        out_s.valid <= 1'b1;
      end else if (out_s.valid && out_s.ready) begin
        out_s.valid <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ClrW'(1);
          if (clr_q == ClrW'(MAX_COLS - 1)) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (head_valid_i) begin
            state_q <= S_CAND;
          end
        end
        S_CAND: begin
          cand_q[0] <= c0;
          cand_q[1] <= c1;
          cand_q[2] <= c2;
          cv_q      <= {c2 != sgaf_pkg::NEG_INF, c1 != sgaf_pkg::NEG_INF,
                        c0 != sgaf_pkg::NEG_INF};
          above_q   <= old_above;
          s_q       <= '0;
          ln_q      <= '0;
          for (int i = 0; i < 3; i++) begin
            e_q[i] <= '0;
            w_q[i] <= '0;
          end
          state_q   <= S_MAX;
        end
        S_MAX: begin
          m_q  <= m_c;
          mv_q <= mv_c;
          for (int i = 0; i < 3; i++) begin
            d_q[i] <= m_c - cand_q[i];
          end
          idx_q   <= '0;
          state_q <= mv_c ? S_E1 : S_VAL;
        end
        S_E1: begin
          ez_q <= !cv_q[idx_q] || (|dsel[VW-1:24]) || (y[24:16] >= 9'd20);
          k_q  <= y[20:16];
          f_q  <= y[15:0];
          state_q <= S_E2;
        end
        S_E2: begin
          base_q  <= t0 - 17'((25'(iprod) + 25'd2048) >> 12);
          state_q <= S_E3;
        end
        S_E3: begin
          e_q[idx_q] <= ez_q ? '0 : ebig[16:0];
          s_q        <= s_q + (ez_q ? 18'd0 : 18'(ebig[16:0]));
          if (idx_q == 2'd2) begin
            state_q <= S_LN1;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_E1;
          end
        end
        S_LN1: begin
          l2_q    <= (ip ? 18'd65536 : 18'd0) + 18'(lg);
          state_q <= S_LN2;
        end
        S_LN2: begin
          ln_q    <= lnprod[32:16];
          state_q <= S_VAL;
        end
        S_VAL: begin
          val_q   <= value_c;
          diag_q  <= head_i.last ? '0 : above_q;
          left_q  <= (head_i.last || head_i.wrap) ? sgaf_pkg::NEG_INF : value_c;
          idx_q   <= '0;
          state_q <= mv_q ? S_DIVI : S_OUT;
        end
        S_DIVI: begin
          rem_q   <= {1'b0, num[33:17]};
          sh_q    <= num[16:0];
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= ge ? 18'(trial - 19'(s_q)) : trial[17:0];
          sh_q   <= {sh_q[15:0], ge};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd16) begin
            w_q[idx_q] <= {sh_q[15:0], ge};
            if (idx_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_DIVI;
            end
          end
        end
        S_OUT: begin
          if (pop_o) begin
            state_q <= S_WAIT;
          end
        end
        default: state_q <= S_WAIT;
      endcase
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_s.cell_value  <= val_q;
      out_s.weight_up   <= w_q[0];
      out_s.weight_diag <= w_q[1];
      out_s.weight_left <= w_q[2];
      out_s.final_score <= head_i.last;
    end
  end

endmodule

// File: rtl/core/soft_global_alignment_forward.sv
// ----------------------------------------------------------------------------
// soft_global_alignment_forward: smoothed global alignment forward pass
// log-sum-exp dynamic programming over a score matrix, one cell per word
// ----------------------------------------------------------------------------
// the serial weight divider, run once for each of the three weights, dominates
//   the time from acceptance to result valid; the back end works on one cell
//   at a time, and the front queue can take one more word meanwhile; a cell
//   with no live candidate skips exp, log and divide
// reset: asynchronous active low; afterwards a clearing pass over all MAX_COLS
//   entries writes minus infinity into the row memory, input ready stays low
// ----------------------------------------------------------------------------
module soft_global_alignment_forward #(
  parameter int MAX_COLS = sgaf_pkg::DEF_MAX_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgaf_in_if.sink     in_s,
  sgaf_out_if.source  out_s,
  sgaf_cfg_if.sink    cfg_s
);

  // configuration registers
  logic signed [sgaf_pkg::VW-1:0]  gap_q;
  logic [sgaf_pkg::NCOLS_W-1:0]    ncols_q;

  // front to back
  sgaf_pkg::item_t                 head;
  logic [$clog2(MAX_COLS)-1:0]     head_col;
  logic                            head_valid;
  logic                            pop;
  logic                            clr_busy;

  // always ready; user keeps block idle whenever one arrives, not enforced
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= '0;
      ncols_q <= sgaf_pkg::NCOLS_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        sgaf_pkg::CFG_GAP:   gap_q   <= cfg_s.data;
        sgaf_pkg::CFG_NCOLS: ncols_q <= cfg_s.data[sgaf_pkg::NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking, row flags and the two-deep word queue
  sgaf_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_s         (in_s),
    .ncols_i      (ncols_q),
    .clr_busy_i   (clr_busy),
    .pop_i        (pop),
    .head_o       (head),
    .head_col_o   (head_col),
    .head_valid_o (head_valid)
  );

  // back: row memory, smoothed max, weights and the result register
  sgaf_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_i        (gap_q),
    .head_i       (head),
    .head_col_i   (head_col),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .clr_busy_o   (clr_busy),
    .out_s        (out_s)
  );

endmodule

// File: rtl/core/sgaf_checker.sv
// ----------------------------------------------------------------------------
// sgaf_checker: port-level checks
// result hold, word accounting and weight range
// ----------------------------------------------------------------------------
module sgaf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [16:0] w_up_i,
  input logic [16:0] w_diag_i,
  input logic [16:0] w_left_i
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before taken");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without an accepted word");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more words in flight than storage");

  a_wgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (w_up_i <= 17'd65536) && (w_diag_i <= 17'd65536) &&
                    (w_left_i <= 17'd65536))
    else $error("weight above one");

endmodule

bind soft_global_alignment_forward sgaf_checker u_sgaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .w_up_i      (out_s.weight_up),
  .w_diag_i    (out_s.weight_diag),
  .w_left_i    (out_s.weight_left)
);
